/* hdl/bounded_array_list_macros.svh */
// Assertion macros used by the bounded array list RTL.
// Standalone header; the asserting module supplies clock and reset names.
`ifndef BOUNDED_ARRAY_LIST_MACROS_SVH
`define BOUNDED_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BAL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded_array_list check failed");

// Next-cycle implication, disabled while in reset.
`define BAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded_array_list check failed");

`endif

/* hdl/bal_pkg.sv */
// Package for the bounded array list: field widths, stream packing,
// request and status codes, and the sequencer state type. No dependencies.
package bal_pkg;

    localparam int BAL_DEPTH = 64;

    // Field widths
    localparam int FUNC_W = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 31;
    localparam int RPOS_W = 6;
    localparam int ST_W   = 3;
    localparam int CNT_W  = 7;

    // Stream packing
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int M_USED_W  = VAL_W + RPOS_W + CNT_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_READ   = 2'd2,
        FN_SEARCH = 2'd3
    } t_func;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_DISP = 11'b000_0000_0010,
        S_SHRD = 11'b000_0000_0100,
        S_SHWR = 11'b000_0000_1000,
        S_INS  = 11'b000_0001_0000,
        S_GOT  = 11'b000_0010_0000,
        S_RMRD = 11'b000_0100_0000,
        S_RMWR = 11'b000_1000_0000,
        S_SRD  = 11'b001_0000_0000,
        S_SCMP = 11'b010_0000_0000,
        S_SEND = 11'b100_0000_0000
    } t_state;

endpackage

/* hdl/bounded_array_list.sv */
// Bounded array list top level: dual-port list memory plus a small sequencer.
// Depends on bal_pkg and bounded_array_list_macros.svh.
//
// Ordered list of up to DEPTH 31-bit entries, one request at a time. Insert
// and remove move the later entries one place through the list memory, one
// entry at a time (read, then write), so both take longer the more entries
// lie after the position. A search reads and compares one entry at a time
// against the request value and gives one beat per match (last beat marked)
// or one not-found beat. Each beat waits in an output register, so a stalled
// master side holds the sequencer only when a new beat must be emitted. Errors
// (full, empty, bad position) give one beat and change nothing. The slave side
// is ready only between requests. No memory clearing pass is needed after
// reset: only entries below the count are ever used.
module bounded_array_list
    import bal_pkg::*;
#(
    parameter int DEPTH = BAL_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request beats
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // position[6:0], value[37:7], zero pad
    input  logic [FUNC_W-1:0]    i_s_axis_tuser,  // func[1:0]
    // result beats
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // result_value[30:0],
                                                  // result_position[36:31],
                                                  // entry_count[43:37], zero pad
    output logic [ST_W-1:0]      o_m_axis_tuser,  // status[2:0]
    output logic                 o_m_axis_tlast   // last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    // request registers
    t_state             r_state, n_state;
    t_func              r_func;
    logic [POS_W-1:0]   r_pos;
    logic [VAL_W-1:0]   r_val;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_hit, n_hit;      // pending search match not yet sent
    logic [AW-1:0]      r_hit_pos, n_hit_pos;

    // list memory
    logic [VAL_W-1:0]   r_mem [DEPTH];
    logic [VAL_W-1:0]   r_rdata;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [VAL_W-1:0]   mem_wdata;

    // output register
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_val;
    logic [RPOS_W-1:0]  r_out_pos;
    t_status            r_out_st;
    logic [CNT_W-1:0]   r_out_cnt;
    logic               r_out_last;

    logic               s_accept;
    logic               out_free;
    logic               emit;
    logic [VAL_W-1:0]   e_val;
    logic [RPOS_W-1:0]  e_pos;
    t_status            e_st;
    logic               e_last;

    logic [AW-1:0]      pos_aw, idx_m1, idx_p1;
    logic [POS_W-1:0]   cnt_p;
    logic               is_full, is_empty, pos_gt, pos_ge, idx_at_cnt, idx_is_last;
    logic               hit;
    logic               err;
    t_status            err_st;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign pos_aw      = r_pos[AW-1:0];
    assign idx_m1      = r_idx - AW'(1);
    assign idx_p1      = r_idx + AW'(1);
    assign cnt_p       = POS_W'(r_count);
    assign is_full     = (r_count == CNT_FULL);
    assign is_empty    = (r_count == '0);
    assign pos_gt      = (r_pos > cnt_p);
    assign pos_ge      = (r_pos >= cnt_p);
    assign idx_at_cnt  = (CW'(r_idx) == r_count);
    assign idx_is_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign hit         = (r_rdata == r_val);

    // error check on the latched request
    always_comb begin
        err    = 1'b0;
        err_st = ST_OK;
        unique case (r_func)
            FN_INSERT: begin
                if (is_full) begin
                    err    = 1'b1;
                    err_st = ST_FULL;
                end else if (pos_gt) begin
                    err    = 1'b1;
                    err_st = ST_RANGE;
                end
            end
            FN_REMOVE, FN_READ: begin
                if (is_empty) begin
                    err    = 1'b1;
                    err_st = ST_EMPTY;
                end else if (pos_ge) begin
                    err    = 1'b1;
                    err_st = ST_RANGE;
                end
            end
            FN_SEARCH: begin
                if (is_empty) begin
                    err    = 1'b1;
                    err_st = ST_EMPTY;
                end
            end
            default: begin
                err    = 1'b0;
                err_st = ST_OK;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_hit     = r_hit;
        n_hit_pos = r_hit_pos;
        emit      = 1'b0;
        e_val     = r_val;
        e_pos     = '0;
        e_st      = ST_OK;
        e_last    = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_rdata;
        mem_raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_hit = 1'b0;
                if (s_accept) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                mem_raddr = pos_aw;
                n_idx     = '0;
                if (err) begin
                    emit = out_free;
                    e_st = err_st;
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    unique case (r_func)
                        FN_INSERT: begin
                            if (r_pos == cnt_p) begin
                                n_state = S_INS;
                            end else begin
                                n_idx   = r_count[AW-1:0];
                                n_state = S_SHRD;
                            end
                        end
                        FN_REMOVE, FN_READ: n_state = S_GOT;
                        FN_SEARCH:          n_state = S_SRD;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            // open a hole at the insert position, top entry first
            S_SHRD: begin
                mem_raddr = idx_m1;
                n_state   = S_SHWR;
            end
            S_SHWR: begin
                mem_raddr = idx_m1;
                mem_we    = 1'b1;
                n_idx     = idx_m1;
                n_state   = (idx_m1 == pos_aw) ? S_INS : S_SHRD;
            end
            S_INS: begin
                if (out_free) begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_aw;
                    mem_wdata = r_val;
                    n_count   = r_count + CW'(1);
                    emit      = 1'b1;
                    e_pos     = RPOS_W'(pos_aw);
                    n_state   = S_IDLE;
                end
            end
            // r_rdata holds the entry at the request position
            S_GOT: begin
                mem_raddr = pos_aw;
                if (out_free) begin
                    emit  = 1'b1;
                    e_val = r_rdata;
                    e_pos = RPOS_W'(pos_aw);
                    if (r_func == FN_REMOVE) begin
                        n_count = r_count - CW'(1);
                        n_idx   = pos_aw;
                        n_state = S_RMRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            // close the gap; count already holds the new size
            S_RMRD: begin
                mem_raddr = idx_p1;
                n_state   = idx_at_cnt ? S_IDLE : S_RMWR;
            end
            S_RMWR: begin
                mem_raddr = idx_p1;
                mem_we    = 1'b1;
                n_idx     = idx_p1;
                n_state   = S_RMRD;
            end
            S_SRD: begin
                n_state = S_SCMP;
            end
            // a match is held back one step so the final one can carry last
            S_SCMP: begin
                if (!(hit && r_hit && !out_free)) begin
                    if (hit) begin
                        if (r_hit) begin
                            emit   = 1'b1;
                            e_pos  = RPOS_W'(r_hit_pos);
                            e_last = 1'b0;
                        end
                        n_hit     = 1'b1;
                        n_hit_pos = r_idx;
                    end
                    if (idx_is_last) begin
                        n_state = S_SEND;
                    end else begin
                        n_idx   = idx_p1;
                        n_state = S_SRD;
                    end
                end
            end
            S_SEND: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_hit) begin
                        e_pos = RPOS_W'(r_hit_pos);
                    end else begin
                        e_st = ST_NOTFOUND;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_hit_pos <= n_hit_pos;
        if (s_accept) begin
            r_func <= t_func'(i_s_axis_tuser);
            r_pos  <= i_s_axis_tdata[POS_W-1:0];
            r_val  <= i_s_axis_tdata[POS_W+VAL_W-1:POS_W];
        end
    end

    // list memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_val  <= e_val;
            r_out_pos  <= e_pos;
            r_out_st   <= e_st;
            r_out_cnt  <= CNT_W'(n_count);
            r_out_last <= e_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W - M_USED_W)'(0), r_out_cnt, r_out_pos, r_out_val};
    assign o_m_axis_tuser  = r_out_st;
    assign o_m_axis_tlast  = r_out_last;

`include "bounded_array_list_macros.svh"

    // the count moves only with the beat that reports it; a final beat ends the
    // request, except that a remove still compacts the list afterwards
    `BAL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)
    `BAL_ASSERT_IMP(a_count_emit, i_clk, i_rst_n, n_count != r_count, emit)
    `BAL_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, emit && e_last, o_s_axis_tready || r_state == S_RMRD)
    `BAL_ASSERT_IMP(a_hit_search, i_clk, i_rst_n, r_hit, r_func == FN_SEARCH)

endmodule
